// ----- design/samu_pkg.sv -----
`timescale 1ns / 1ps
// shared types and constants of the square matrix arithmetic unit
package samu_pkg;

    localparam int VAL_W  = 16;
    localparam int PROD_W = 32;
    localparam int RES_W  = 36;
    localparam int OP_W   = 2;

    typedef enum logic [OP_W-1:0] {
        OP_ADD    = 2'd0,
        OP_SUB_AB = 2'd1,
        OP_SUB_BA = 2'd2,
        OP_MUL    = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ST_LOAD,
        ST_ISSUE,
        ST_DRAIN
    } state_t;

    // one read issue from the controller into the datapath
    typedef struct packed {
        logic rd_en;
        logic first;
        logic last;
        logic final_elem;
        op_t  op;
    } cmd_t;

    typedef struct packed {
        logic out_free;
        logic res_done;
    } status_t;

endpackage

// ----- design/samu_ifs.sv -----
`timescale 1ns / 1ps
// valid/ready channel interfaces for operand beats and result beats
interface samu_load_if;
    logic                               valid;
    logic                               ready;
    logic signed [samu_pkg::VAL_W-1:0]  a_value;
    logic signed [samu_pkg::VAL_W-1:0]  b_value;

    modport source (output valid, output a_value, output b_value, input ready);
    modport sink   (input valid, input a_value, input b_value, output ready);
endinterface

interface samu_result_if;
    logic                               valid;
    logic                               ready;
    logic signed [samu_pkg::RES_W-1:0]  result_value;
    logic                               is_last;

    modport source (output valid, output result_value, output is_last, input ready);
    modport sink   (input valid, input result_value, input is_last, output ready);
endinterface

// ----- design/samu_ram.sv -----
`timescale 1ns / 1ps
// generic single-write single-read ram with registered read data
module samu_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- design/samu_ctrl.sv -----
`timescale 1ns / 1ps
// controller: load sequencing, element and k loop counters, read issue
module samu_ctrl #(
    parameter int DIM = 4
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                load_valid,
    output logic                                load_ready,
    input  logic                                cfg_write,
    input  logic [samu_pkg::OP_W-1:0]           cfg_data,
    input  samu_pkg::status_t                   status,
    output samu_pkg::cmd_t                      cmd,
    output logic                                wr_en,
    output logic [$clog2(DIM*DIM)-1:0]          wr_addr,
    output logic [$clog2(DIM*DIM)-1:0]          rd_addr_a,
    output logic [$clog2(DIM*DIM)-1:0]          rd_addr_b
);

    localparam int ELEMS = DIM * DIM;
    localparam int IDX_W = $clog2(ELEMS);
    localparam int K_W   = $clog2(DIM);

    samu_pkg::state_t state_reg, state_next;
    samu_pkg::op_t    op_reg;

    logic [IDX_W-1:0] load_cnt_reg, load_cnt_next;
    logic [IDX_W-1:0] row_base_reg, row_base_next;
    logic [IDX_W-1:0] k_base_reg, k_base_next;
    logic [K_W-1:0]   col_reg, col_next;
    logic [K_W-1:0]   k_reg, k_next;

    logic load_done;
    logic is_mul;
    logic elem_last_k;
    logic elem_final;

    assign load_done   = load_valid && (load_cnt_reg == IDX_W'(ELEMS - 1));
    assign is_mul      = (op_reg == samu_pkg::OP_MUL);
    assign elem_last_k = !is_mul || (k_reg == K_W'(DIM - 1));
    assign elem_final  = (row_base_reg == IDX_W'(ELEMS - DIM)) && (col_reg == K_W'(DIM - 1));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= samu_pkg::ST_LOAD;
            op_reg       <= samu_pkg::OP_ADD;
            load_cnt_reg <= '0;
            row_base_reg <= '0;
            k_base_reg   <= '0;
            col_reg      <= '0;
            k_reg        <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            load_cnt_reg <= load_cnt_next;
            row_base_reg <= row_base_next;
            k_base_reg   <= k_base_next;
            col_reg      <= col_next;
            k_reg        <= k_next;
            if (cfg_write)
            begin
                op_reg <= samu_pkg::op_t'(cfg_data);
            end
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            samu_pkg::ST_LOAD:
            begin
                if (load_done)
                begin
                    state_next = samu_pkg::ST_ISSUE;
                end
            end
            samu_pkg::ST_ISSUE:
            begin
                if (status.out_free && elem_last_k)
                begin
                    state_next = samu_pkg::ST_DRAIN;
                end
            end
            samu_pkg::ST_DRAIN:
            begin
                if (status.res_done)
                begin
                    state_next = elem_final ? samu_pkg::ST_LOAD : samu_pkg::ST_ISSUE;
                end
            end
            default:
            begin
                state_next = samu_pkg::ST_LOAD;
            end
        endcase
    end

    // outputs
    always_comb
    begin
        load_ready     = 1'b0;
        wr_en          = 1'b0;
        cmd.rd_en      = 1'b0;
        cmd.first      = (k_reg == '0);
        cmd.last       = elem_last_k;
        cmd.final_elem = elem_final;
        cmd.op         = op_reg;
        case (state_reg)
            samu_pkg::ST_LOAD:
            begin
                load_ready = 1'b1;
                wr_en      = load_valid;
            end
            samu_pkg::ST_ISSUE:
            begin
                cmd.rd_en = status.out_free;
            end
            samu_pkg::ST_DRAIN:
            begin
                cmd.rd_en = 1'b0;
            end
            default:
            begin
                cmd.rd_en = 1'b0;
            end
        endcase
    end

    assign wr_addr   = load_cnt_reg;
    // product walks a row of A and a column of B; elementwise ops read the same slot
    assign rd_addr_a = is_mul ? row_base_reg + IDX_W'(k_reg) : row_base_reg + IDX_W'(col_reg);
    assign rd_addr_b = is_mul ? k_base_reg + IDX_W'(col_reg) : row_base_reg + IDX_W'(col_reg);

    // loop counters
    always_comb
    begin
        load_cnt_next = load_cnt_reg;
        row_base_next = row_base_reg;
        k_base_next   = k_base_reg;
        col_next      = col_reg;
        k_next        = k_reg;
        case (state_reg)
            samu_pkg::ST_LOAD:
            begin
                if (load_valid)
                begin
                    load_cnt_next = load_done ? '0 : load_cnt_reg + 1'b1;
                end
                if (load_done)
                begin
                    row_base_next = '0;
                    k_base_next   = '0;
                    col_next      = '0;
                    k_next        = '0;
                end
            end
            samu_pkg::ST_ISSUE:
            begin
                if (status.out_free)
                begin
                    if (elem_last_k)
                    begin
                        k_next      = '0;
                        k_base_next = '0;
                    end
                    else
                    begin
                        k_next      = k_reg + 1'b1;
                        k_base_next = k_base_reg + IDX_W'(DIM);
                    end
                end
            end
            samu_pkg::ST_DRAIN:
            begin
                if (status.res_done)
                begin
                    if (elem_final)
                    begin
                        col_next      = '0;
                        row_base_next = '0;
                    end
                    else if (col_reg == K_W'(DIM - 1))
                    begin
                        col_next      = '0;
                        row_base_next = row_base_reg + IDX_W'(DIM);
                    end
                    else
                    begin
                        col_next = col_reg + 1'b1;
                    end
                end
            end
            default:
            begin
                k_next = '0;
            end
        endcase
    end

endmodule

// ----- design/samu_dp.sv -----
`timescale 1ns / 1ps
// datapath: operand rams, combine stage, accumulator and output register
module samu_dp #(
    parameter int DIM = 4
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic signed [samu_pkg::VAL_W-1:0]  a_value,
    input  logic signed [samu_pkg::VAL_W-1:0]  b_value,
    input  logic                               wr_en,
    input  logic [$clog2(DIM*DIM)-1:0]         wr_addr,
    input  logic [$clog2(DIM*DIM)-1:0]         rd_addr_a,
    input  logic [$clog2(DIM*DIM)-1:0]         rd_addr_b,
    input  samu_pkg::cmd_t                     cmd,
    output samu_pkg::status_t                  status,
    samu_result_if.source                      result
);

    localparam int ELEMS = DIM * DIM;

    logic signed [samu_pkg::VAL_W-1:0]  a_rd;
    logic signed [samu_pkg::VAL_W-1:0]  b_rd;

    logic                               s1_valid_reg;
    logic                               s1_first_reg;
    logic                               s1_last_reg;
    logic                               s1_final_reg;
    samu_pkg::op_t                      s1_op_reg;

    logic signed [samu_pkg::PROD_W-1:0] prod_next;
    logic signed [samu_pkg::PROD_W-1:0] prod_reg;
    logic                               s2_valid_reg;
    logic                               s2_first_reg;
    logic                               s2_last_reg;
    logic                               s2_final_reg;

    logic signed [samu_pkg::RES_W-1:0]  acc_reg;
    logic signed [samu_pkg::RES_W-1:0]  acc_sum;
    logic                               res_done;

    logic                               out_valid_reg;
    logic signed [samu_pkg::RES_W-1:0]  out_value_reg;
    logic                               out_last_reg;

    samu_ram #(
        .WIDTH (samu_pkg::VAL_W),
        .DEPTH (ELEMS)
    ) u_ram_a (
        .clk   (clk),
        .we    (wr_en),
        .waddr (wr_addr),
        .wdata (a_value),
        .re    (cmd.rd_en),
        .raddr (rd_addr_a),
        .rdata (a_rd)
    );

    samu_ram #(
        .WIDTH (samu_pkg::VAL_W),
        .DEPTH (ELEMS)
    ) u_ram_b (
        .clk   (clk),
        .we    (wr_en),
        .waddr (wr_addr),
        .wdata (b_value),
        .re    (cmd.rd_en),
        .raddr (rd_addr_b),
        .rdata (b_rd)
    );

    // tags travel alongside the ram read
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= cmd.rd_en;
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.rd_en)
        begin
            s1_first_reg <= cmd.first;
            s1_last_reg  <= cmd.last;
            s1_final_reg <= cmd.final_elem;
            s1_op_reg    <= cmd.op;
        end
        if (s1_valid_reg)
        begin
            prod_reg     <= prod_next;
            s2_first_reg <= s1_first_reg;
            s2_last_reg  <= s1_last_reg;
            s2_final_reg <= s1_final_reg;
        end
        if (s2_valid_reg)
        begin
            acc_reg <= acc_sum;
        end
    end

    always_comb
    begin
        case (s1_op_reg)
            samu_pkg::OP_ADD:
            begin
                prod_next = samu_pkg::PROD_W'(a_rd) + samu_pkg::PROD_W'(b_rd);
            end
            samu_pkg::OP_SUB_AB:
            begin
                prod_next = samu_pkg::PROD_W'(a_rd) - samu_pkg::PROD_W'(b_rd);
            end
            samu_pkg::OP_SUB_BA:
            begin
                prod_next = samu_pkg::PROD_W'(b_rd) - samu_pkg::PROD_W'(a_rd);
            end
            samu_pkg::OP_MUL:
            begin
                prod_next = a_rd * b_rd;
            end
            default:
            begin
                prod_next = '0;
            end
        endcase
    end

    // first term of an element restarts the sum
    assign acc_sum  = (s2_first_reg ? '0 : acc_reg) + samu_pkg::RES_W'(prod_reg);
    assign res_done = s2_valid_reg && s2_last_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (res_done)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (result.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_done)
        begin
            out_value_reg <= acc_sum;
            out_last_reg  <= s2_final_reg;
        end
    end

    assign result.valid        = out_valid_reg;
    assign result.result_value = out_value_reg;
    assign result.is_last      = out_last_reg;

    assign status.out_free = !out_valid_reg || result.ready;
    assign status.res_done = res_done;

endmodule

// ----- design/square_matrix_arith_unit.sv -----
`timescale 1ns / 1ps
// top level of the square matrix arithmetic unit
//
//  channel   dir   beat contents              handshake
//  load      in    a_value, b_value           valid / ready
//  result    out   result_value, is_last      valid / ready
//  cfg       in    cfg_data (operation)       cfg_write, no ready
//
// loading takes one beat per cycle for DIM*DIM beats, then the block stops
// taking beats and computes each result element: the product makes one
// operand-ram read per k, set by the single read port of each ram, while add
// and subtract make one read per element.
// a stalled result beat holds the next element's reads; loading of the next
// pair resumes as soon as the final element sits in the output register.
// reset clears the controller, the operation (add) and all valid flags.
module square_matrix_arith_unit #(
    parameter int DIM = 4
) (
    input  logic                          clk,
    input  logic                          rst_n,
    samu_load_if.sink                     load,
    samu_result_if.source                 result,
    input  logic                          cfg_write,
    input  logic [samu_pkg::OP_W-1:0]     cfg_data
);

    localparam int IDX_W = $clog2(DIM * DIM);

    samu_pkg::cmd_t    cmd;
    samu_pkg::status_t status;
    logic              wr_en;
    logic [IDX_W-1:0]  wr_addr;
    logic [IDX_W-1:0]  rd_addr_a;
    logic [IDX_W-1:0]  rd_addr_b;

    samu_ctrl #(
        .DIM (DIM)
    ) u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .load_valid (load.valid),
        .load_ready (load.ready),
        .cfg_write  (cfg_write),
        .cfg_data   (cfg_data),
        .status     (status),
        .cmd        (cmd),
        .wr_en      (wr_en),
        .wr_addr    (wr_addr),
        .rd_addr_a  (rd_addr_a),
        .rd_addr_b  (rd_addr_b)
    );

    samu_dp #(
        .DIM (DIM)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .a_value   (load.a_value),
        .b_value   (load.b_value),
        .wr_en     (wr_en),
        .wr_addr   (wr_addr),
        .rd_addr_a (rd_addr_a),
        .rd_addr_b (rd_addr_b),
        .cmd       (cmd),
        .status    (status),
        .result    (result)
    );

endmodule

// ----- sim/square_matrix_arith_unit_tb.sv -----
`timescale 1ns / 1ps
// self-checking testbench for the square matrix arithmetic unit
module square_matrix_arith_unit_tb;
    import samu_pkg::*;

    localparam int DIM           = 4;
    localparam int ELEMS         = DIM * DIM;
    localparam int RANDOM_ITEMS  = 100;
    localparam int MAX_WAIT      = 12;
    localparam int HOLD_CYCLES   = 300;
    localparam int SETTLE_CYCLES = 3 * (DIM + 2);
    localparam int REPORT_LIMIT  = 10;

    typedef struct {
        logic signed [VAL_W-1:0] a;
        logic signed [VAL_W-1:0] b;
    } operand_pair_t;

    typedef struct {
        logic signed [RES_W-1:0] value;
        logic                    last;
    } matrix_elem_t;

    logic            clk = 1'b0;
    logic            rst_n = 1'b0;
    logic            cfg_write = 1'b0;
    logic [OP_W-1:0] cfg_data = OP_ADD;

    samu_load_if   operand_bus ();
    samu_result_if result_bus ();

    square_matrix_arith_unit #(
        .DIM(DIM)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .load(operand_bus),
        .result(result_bus),
        .cfg_write(cfg_write),
        .cfg_data(cfg_data)
    );

    // predictor state: mirror of the operand stores and the operation register
    logic signed [VAL_W-1:0] a_mat [ELEMS];
    logic signed [VAL_W-1:0] b_mat [ELEMS];
    int                      fill_count = 0;
    op_t                     op_now = OP_ADD;

    operand_pair_t operand_backlog [$];
    matrix_elem_t  expected_elems [$];

    int gap_left = 0;
    int stall_left = 0;
    int hold_left = 0;
    bit hold_armed = 1'b0;
    bit no_gaps = 1'b0;
    int mismatch_count = 0;
    int elems_seen = 0;
    int items_queued = 0;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic logic signed [RES_W-1:0] matrix_element(int row, int col);
        longint acc;
        int     idx;
        idx = row * DIM + col;
        acc = 0;
        case (op_now)
            OP_ADD:    acc = longint'(a_mat[idx]) + longint'(b_mat[idx]);
            OP_SUB_AB: acc = longint'(a_mat[idx]) - longint'(b_mat[idx]);
            OP_SUB_BA: acc = longint'(b_mat[idx]) - longint'(a_mat[idx]);
            default:
            begin
                for (int k = 0; k < DIM; k++)
                    acc += longint'(a_mat[row * DIM + k]) * longint'(b_mat[k * DIM + col]);
            end
        endcase
        return acc[RES_W-1:0];
    endfunction

    // the beat that completes both matrices releases the whole result matrix
    task automatic load_operand_pair(logic signed [VAL_W-1:0] a, logic signed [VAL_W-1:0] b);
        matrix_elem_t e;
        a_mat[fill_count] = a;
        b_mat[fill_count] = b;
        fill_count++;
        if (fill_count == ELEMS)
        begin
            fill_count = 0;
            for (int r = 0; r < DIM; r++)
                for (int c = 0; c < DIM; c++)
                begin
                    e.value = matrix_element(r, c);
                    e.last  = (r == DIM - 1) && (c == DIM - 1);
                    expected_elems.push_back(e);
                end
        end
    endtask

    task automatic flag_mismatch(string field, longint want, longint got);
        mismatch_count++;
        if (mismatch_count <= REPORT_LIMIT)
            $display("mismatch on %s of result %0d: expected %0d, got %0d",
                     field, elems_seen, want, got);
    endtask

    // operand driver
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            operand_bus.valid <= 1'b0;
            gap_left = 0;
        end
        else
        begin
            if (operand_bus.valid && operand_bus.ready)
            begin
                load_operand_pair(operand_bus.a_value, operand_bus.b_value);
                gap_left = no_gaps ? 0 : $urandom_range(0, MAX_WAIT);
            end
            if (operand_bus.valid && !operand_bus.ready)
                ;
            else if (gap_left > 0)
            begin
                gap_left--;
                operand_bus.valid <= 1'b0;
            end
            else if (operand_backlog.size() != 0)
            begin
                operand_pair_t p;
                p = operand_backlog.pop_front();
                operand_bus.valid   <= 1'b1;
                operand_bus.a_value <= p.a;
                operand_bus.b_value <= p.b;
            end
            else
                operand_bus.valid <= 1'b0;
        end
    end

    // long receiver hold-off, armed by the stimulus, started by the next result beat
    always @(posedge clk)
    begin
        if (!rst_n)
            hold_left <= 0;
        else if (hold_left != 0)
            hold_left <= hold_left - 1;
        else if (hold_armed && result_bus.valid)
        begin
            hold_left <= HOLD_CYCLES;
            hold_armed = 1'b0;
        end
    end

    // result monitor and checker
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            result_bus.ready <= 1'b0;
            stall_left = 0;
        end
        else
        begin
            if (result_bus.valid && result_bus.ready)
            begin
                if (expected_elems.size() == 0)
                    flag_mismatch("unexpected beat result_value", 0, result_bus.result_value);
                else
                begin
                    matrix_elem_t want;
                    want = expected_elems.pop_front();
                    if (result_bus.result_value !== want.value)
                        flag_mismatch("result_value", want.value, result_bus.result_value);
                    if (result_bus.is_last !== want.last)
                        flag_mismatch("is_last", want.last, result_bus.is_last);
                end
                elems_seen++;
                stall_left = no_gaps ? 0 : $urandom_range(0, MAX_WAIT);
            end
            if (hold_left != 0)
                result_bus.ready <= 1'b0;
            else if (stall_left > 0)
            begin
                stall_left--;
                result_bus.ready <= 1'b0;
            end
            else
                result_bus.ready <= 1'b1;
        end
    end

    function automatic logic signed [VAL_W-1:0] draw_operand();
        logic signed [VAL_W-1:0] v;
        int                      offset;
        case ($urandom_range(0, 4))
            0:
            begin
                case ($urandom_range(0, 3))
                    0:       v = 16'sh8000;
                    1:       v = 16'sh7fff;
                    2:       v = 16'sh0000;
                    default: v = 16'shffff;
                endcase
            end
            1:
            begin
                offset = $urandom_range(0, 16);
                v = VAL_W'(offset - 8);
            end
            default: v = VAL_W'($urandom());
        endcase
        return v;
    endfunction

    task automatic queue_pair(logic signed [VAL_W-1:0] a, logic signed [VAL_W-1:0] b);
        operand_pair_t p;
        p.a = a;
        p.b = b;
        operand_backlog.push_back(p);
        items_queued++;
    endtask

    task automatic queue_random(int count);
        for (int i = 0; i < count; i++)
            queue_pair(draw_operand(), draw_operand());
    endtask

    task automatic wait_idle();
        while (operand_backlog.size() != 0 || operand_bus.valid || expected_elems.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic change_operation(op_t op);
        wait_idle();
        @(posedge clk);
        cfg_write <= 1'b1;
        cfg_data  <= op;
        @(posedge clk);
        cfg_write <= 1'b0;
        op_now = op;
        @(negedge clk);
    endtask

    initial
    begin
        op_t op_order [4];
        op_t op;
        int  phase;
        int  sets;
        int  random_start;

        op_order = '{OP_SUB_AB, OP_SUB_BA, OP_ADD, OP_MUL};
        operand_bus.valid   = 1'b0;
        operand_bus.a_value = '0;
        operand_bus.b_value = '0;
        result_bus.ready    = 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // operation left at its reset value: add, with the operand extremes
        for (int i = 0; i < ELEMS; i++)
        begin
            case (i % 4)
                0: queue_pair(16'sh8000, 16'sh8000);
                1: queue_pair(16'sh7fff, 16'sh7fff);
                2: queue_pair(16'sh0000, 16'shffff);
                default: queue_pair(16'shffff, 16'sh8000);
            endcase
        end

        // product switched on halfway through loading; A all minimum, B columns
        // of minimum then maximum reach both ends of the product range
        for (int i = 0; i < ELEMS / 2; i++)
            queue_pair(16'sh8000, (i % DIM < DIM / 2) ? 16'sh8000 : 16'sh7fff);
        change_operation(OP_MUL);
        for (int i = ELEMS / 2; i < ELEMS; i++)
            queue_pair(16'sh8000, (i % DIM < DIM / 2) ? 16'sh8000 : 16'sh7fff);

        random_start = items_queued;
        phase = 0;
        while (items_queued - random_start < RANDOM_ITEMS)
        begin
            op = (phase < 4) ? op_order[phase] : op_t'($urandom_range(0, 3));
            change_operation(op);
            no_gaps = ($urandom_range(0, 3) == 0);
            hold_armed = (phase == 0) || ($urandom_range(0, 5) == 0);
            sets = hold_armed ? 3 : $urandom_range(1, 2);
            queue_random(sets * ELEMS);
            // sometimes leave a pair half loaded across the next register write
            if ($urandom_range(0, 2) == 0)
                queue_random($urandom_range(1, ELEMS - 1));
            phase++;
        end
        no_gaps = 1'b0;
        queue_random((ELEMS - items_queued % ELEMS) % ELEMS);

        wait_idle();
        if (mismatch_count == 0)
            $display("[square_matrix_arith_unit] OK");
        else
            $display("[square_matrix_arith_unit] ERROR");
        $finish;
    end

    initial
    begin
        #5_000_000;
        $display("[square_matrix_arith_unit] ERROR");
        $finish;
    end

endmodule

// ----- filelist.f -----
design/samu_pkg.sv
design/samu_ifs.sv
design/samu_ram.sv
design/samu_ctrl.sv
design/samu_dp.sv
design/square_matrix_arith_unit.sv
sim/square_matrix_arith_unit_tb.sv
